/* design/cfb_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the checksum frame builder.
// No dependencies; every other design file imports this package.
package cfb_pkg;

  localparam int          ByteW        = 8;
  localparam logic [7:0]  MaxPayload   = 8'd249;
  localparam logic [7:0]  FrameOverhead = 8'd6;
  localparam int          QueueDepth   = 4;
  localparam int          QueuePtrW    = $clog2(QueueDepth);
  localparam int          QueueCntW    = $clog2(QueueDepth + 1);

  // Configuration register indexes
  localparam logic [1:0] REG_NODE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_HEADER_START = 2'd1;
  localparam logic [1:0] REG_TEXT_START   = 2'd2;

  typedef struct packed {
    logic [7:0] dest_address;
    logic [7:0] payload_len;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       length_error;
  } out_item_t;

  typedef struct packed {
    logic [7:0] node_address;
    logic [7:0] header_start_code;
    logic [7:0] text_start_code;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    CMD_ERROR,
    CMD_START,
    CMD_DATA
  } cmd_kind_t;

  // One classified input item, as queued between front and back
  typedef struct packed {
    cmd_kind_t  kind;
    logic       ping;       // start of a frame with no payload
    logic       last;       // checksum follows this item's data byte
    logic [7:0] dest;
    logic [7:0] frame_len;  // payload length plus overhead
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_SOH,
    PH_LEN,
    PH_SRC,
    PH_DST,
    PH_STX,
    PH_DATA,
    PH_CHK
  } phase_t;

endpackage

/* design/cfb_front.sv */
`timescale 1ns / 1ps
// Front end: classifies each accepted input item against the frame state.
// Depends on cfb_pkg.
module cfb_front import cfb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t item,
  output cmd_t     cmd
);

  logic       in_frame;
  logic       in_frame_next;
  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;

  // Classify the item and work out the frame state that follows it
  always_comb begin
    cmd.dest      = item.dest_address;
    cmd.frame_len = item.payload_len + FrameOverhead;
    cmd.data      = item.data_byte;
    cmd.ping      = 1'b0;
    cmd.last      = 1'b0;
    in_frame_next   = in_frame;
    bytes_left_next = bytes_left;
    if (in_frame) begin
      cmd.kind        = CMD_DATA;
      cmd.last        = (bytes_left == 8'd1);
      bytes_left_next = bytes_left - 8'd1;
      in_frame_next   = (bytes_left != 8'd1);
    end else if (item.payload_len > MaxPayload) begin
      cmd.kind = CMD_ERROR;
    end else begin
      cmd.kind        = CMD_START;
      cmd.ping        = (item.payload_len == 8'd0);
      cmd.last        = (item.payload_len == 8'd1);
      bytes_left_next = item.payload_len - 8'd1;
      in_frame_next   = (item.payload_len > 8'd1);
    end
  end

  // Advance frame state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      bytes_left <= '0;
    end else if (accept) begin
      in_frame   <= in_frame_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

/* design/cfb_queue.sv */
`timescale 1ns / 1ps
// Short command queue between the front and back ends.
// Depends on cfb_pkg.
module cfb_queue import cfb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t                 mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;

  assign full       = (count == QueueCntW'(QueueDepth));
  assign head_valid = (count != '0);
  assign head_cmd   = mem[rd_ptr];

  // Write the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/cfb_back.sv */
`timescale 1ns / 1ps
// Back end: expands queued commands into frame bytes, keeps the running sum
// and holds the output register. Depends on cfb_pkg.
module cfb_back import cfb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t cfg,
  input  logic      head_valid,
  input  cmd_t      head_cmd,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  phase_t     phase;
  phase_t     phase_next;
  phase_t     cur;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic       adv;
  out_item_t  item_next;

  // Emit when the output slot is free or being drained
  assign adv = head_valid && (!out_valid || !out_stall);

  // Select the byte for this phase and the phase that follows
  always_comb begin
    cur = phase;
    if (head_cmd.kind == CMD_DATA && phase == PH_SOH) begin
      cur = PH_DATA;
    end
    item_next        = '{out_byte: '0, frame_end: 1'b0, length_error: 1'b0};
    phase_next       = phase;
    running_sum_next = running_sum;
    pop              = 1'b0;
    if (head_cmd.kind == CMD_ERROR) begin
      item_next = '{out_byte: '0, frame_end: 1'b1, length_error: 1'b1};
      pop       = adv;
    end else begin
      case (cur)
        PH_SOH: begin
          item_next.out_byte = cfg.header_start_code;
          phase_next         = PH_LEN;
        end
        PH_LEN: begin
          item_next.out_byte = head_cmd.frame_len;
          phase_next         = PH_SRC;
        end
        PH_SRC: begin
          item_next.out_byte = cfg.node_address;
          phase_next         = PH_DST;
        end
        PH_DST: begin
          item_next.out_byte = head_cmd.dest;
          phase_next         = PH_STX;
        end
        PH_STX: begin
          item_next.out_byte = cfg.text_start_code;
          phase_next         = head_cmd.ping ? PH_CHK : PH_DATA;
        end
        PH_DATA: begin
          item_next.out_byte = head_cmd.data;
          if (head_cmd.last) begin
            phase_next = PH_CHK;
          end else begin
            phase_next = PH_SOH;
            pop        = adv;
          end
        end
        PH_CHK: begin
          item_next.out_byte  = 8'd0 - running_sum;
          item_next.frame_end = 1'b1;
          phase_next          = PH_SOH;
          pop                 = adv;
        end
        default: begin
          phase_next = PH_SOH;
        end
      endcase
      // Start the sum afresh on the header's first byte
      running_sum_next = (cur == PH_SOH) ? item_next.out_byte
                                         : running_sum + item_next.out_byte;
    end
  end

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SOH;
    end else if (adv) begin
      phase <= phase_next;
    end
  end

  // Running sum of bytes sent in the frame
  always_ff @(posedge clk) begin
    if (adv) begin
      running_sum <= running_sum_next;
    end
  end

  // Output register: hold while stalled, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= item_next;
    end
  end

endmodule

/* design/checksum_frame_builder_unit.sv */
`timescale 1ns / 1ps
// Frame builder with two's complement sum checksum: top level.
// An item passes the queue, then the output register. Throughput: one result
// byte per cycle unless stalled or the queue is empty; a frame's first item gives
// the header, its data byte and/or checksum; later items data (last: checksum too).
// Reset: synchronous rst clears frame state, queue and output; registers get
// node_address 0, header_start_code 1, text_start_code 2. Depends on cfb_pkg.
module checksum_frame_builder_unit import cfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_regs_t cfg;
  logic      accept;
  logic      q_full;
  logic      head_valid;
  logic      pop;
  cmd_t      front_cmd;
  cmd_t      head_cmd;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{node_address: 8'd0, header_start_code: 8'd1, text_start_code: 8'd2};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NODE_ADDRESS: cfg.node_address      <= cfg_data;
        REG_HEADER_START: cfg.header_start_code <= cfg_data;
        REG_TEXT_START:   cfg.text_start_code   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cfb_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_item),
    .cmd    (front_cmd)
  );

  cfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_cmd   (front_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  cfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

/* design/cfb_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the frame builder, bound to the top level.
// Depends on cfb_pkg.
module cfb_checker import cfb_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Error result always ends the run
  a_err_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.length_error |-> out_item.frame_end)
    else $error("length error without frame end");

  // Error result carries a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.length_error |-> out_item.out_byte == 8'd0)
    else $error("length error with nonzero byte");

  // No result right after reset
  a_rst_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind checksum_frame_builder_unit cfb_checker u_cfb_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for checksum_frame_builder_unit: directed table, then random frames.
// Predicts every frame byte, checksum and length error. Depends on cfb_pkg and the design.
module tb_top;
  import cfb_pkg::*;

  localparam logic [1:0] REG_UNUSED  = 2'd3;  // no register behind this index
  localparam int         DrainCycles = 8;
  localparam int         DirRows     = 13;

  typedef struct {
    in_item_t  item;
    int        n_typed;     // 0: take the predictor's bytes
    out_item_t typed [7];
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = REG_NODE_ADDRESS;
  logic [7:0] cfg_data = 8'h00;

  checksum_frame_builder_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Frame builder shadow: registers and frame state
  cfg_regs_t  cfg_shadow = '{8'h00, 8'h01, 8'h02};
  logic       tx_in_frame = 1'b0;
  logic [7:0] tx_left = 8'h00;
  logic [7:0] tx_sum = 8'h00;

  out_item_t  step_bytes_q [$];   // bytes caused by the item being predicted
  out_item_t  frame_bytes_q [$];  // bytes still owed by the block
  stim_row_t  stim_q [$];
  stim_row_t  cur_row;
  int         items_queued = 0;
  int         items_taken = 0;
  int         gap_pct = 24;
  int         mismatch_count = 0;

  // Directed table: extremes, pings, length errors, ignored fields inside a frame
  in_item_t dir_item [DirRows] = '{
    '{8'h00, 8'd0,   8'hAB},  // ping, data ignored
    '{8'h00, 8'd250, 8'h00},  // first length out of range
    '{8'hFF, 8'd255, 8'hFF},  // largest length
    '{8'hFF, 8'd0,   8'h00},  // ping to the top address
    '{8'h55, 8'd1,   8'hFF},  // single byte frame
    '{8'hAA, 8'd2,   8'h00},
    '{8'hFF, 8'd255, 8'hFF},  // inside a frame: length field ignored
    '{8'h0F, 8'd3,   8'h80},
    '{8'h00, 8'd0,   8'h7F},  // inside a frame: zero length ignored
    '{8'hF0, 8'd250, 8'h01},
    '{8'h33, 8'd251, 8'hCC},
    '{8'h5A, 8'd0,   8'hFF},
    '{8'h00, 8'd1,   8'h00}
  };
  int dir_typed_n [DirRows] = '{6, 1, 1, 6, 0, 0, 0, 0, 0, 0, 1, 6, 0};
  out_item_t dir_typed [$] = '{
    '{8'h01, 1'b0, 1'b0}, '{8'h06, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0}, '{8'h02, 1'b0, 1'b0}, '{8'hF7, 1'b1, 1'b0},
    '{8'h00, 1'b1, 1'b1},
    '{8'h00, 1'b1, 1'b1},
    '{8'h01, 1'b0, 1'b0}, '{8'h06, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0}, '{8'h02, 1'b0, 1'b0}, '{8'hF8, 1'b1, 1'b0},
    '{8'h00, 1'b1, 1'b1},
    '{8'h01, 1'b0, 1'b0}, '{8'h06, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
    '{8'h5A, 1'b0, 1'b0}, '{8'h02, 1'b0, 1'b0}, '{8'h9D, 1'b1, 1'b0}
  };

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Emit one frame byte and fold it into the running sum
  task automatic add_sum_byte(input logic [7:0] b);
    out_item_t r;
    r.out_byte = b;
    r.frame_end = 1'b0;
    r.length_error = 1'b0;
    tx_sum = tx_sum + b;
    step_bytes_q = {step_bytes_q, r};
  endtask

  // Close the frame with the negated sum
  task automatic add_checksum();
    out_item_t r;
    r.out_byte = ~tx_sum + 8'd1;
    r.frame_end = 1'b1;
    r.length_error = 1'b0;
    step_bytes_q = {step_bytes_q, r};
    tx_in_frame = 1'b0;
    tx_left = 8'h00;
    tx_sum = 8'h00;
  endtask

  task automatic predict_frame_step(input in_item_t it);
    out_item_t r;
    step_bytes_q.delete();
    if (tx_in_frame) begin
      add_sum_byte(it.data_byte);
      tx_left = tx_left - 8'd1;
      if (tx_left == 8'd0) add_checksum();
    end else if (it.payload_len > MaxPayload) begin
      r.out_byte = 8'h00;
      r.frame_end = 1'b1;
      r.length_error = 1'b1;
      step_bytes_q = {step_bytes_q, r};
    end else begin
      tx_sum = 8'h00;
      add_sum_byte(cfg_shadow.header_start_code);
      add_sum_byte(it.payload_len + FrameOverhead);
      add_sum_byte(cfg_shadow.node_address);
      add_sum_byte(it.dest_address);
      add_sum_byte(cfg_shadow.text_start_code);
      if (it.payload_len == 8'd0) begin
        add_checksum();
      end else begin
        add_sum_byte(it.data_byte);
        tx_left = it.payload_len - 8'd1;
        tx_in_frame = 1'b1;
        if (tx_left == 8'd0) add_checksum();
      end
    end
  endtask

  // Record the bytes owed for an accepted item
  task automatic take_item(input stim_row_t row);
    items_taken++;
    predict_frame_step(row.item);
    if (row.n_typed > 0) begin
      for (int k = 0; k < row.n_typed; k++) frame_bytes_q = {frame_bytes_q, row.typed[k]};
    end else begin
      frame_bytes_q = {frame_bytes_q, step_bytes_q};
    end
  endtask

  task automatic check_frame_byte(input out_item_t got);
    out_item_t want;
    if (frame_bytes_q.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h", got.out_byte));
      return;
    end
    want = frame_bytes_q.pop_front();
    if (got.out_byte !== want.out_byte)
      report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
    if (got.frame_end !== want.frame_end)
      report_mismatch($sformatf("frame_end %b, want %b on byte %02h",
                                got.frame_end, want.frame_end, want.out_byte));
    if (got.length_error !== want.length_error)
      report_mismatch($sformatf("length_error %b, want %b on byte %02h",
                                got.length_error, want.length_error, want.out_byte));
  endtask

  // Input side: hold a stalled transfer, otherwise offer the next item or idle
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) take_item(cur_row);
      if (!(in_valid && in_stall)) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          cur_row = stim_q.pop_front();
          in_item <= cur_row.item;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each transfer, stall at random
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) check_frame_byte(out_item);
      out_stall <= ($urandom_range(99) < gap_pct);
    end
  end

  task automatic queue_item(input stim_row_t row);
    items_queued++;
    stim_q = {stim_q, row};
  endtask

  // Mostly well-formed frames with random content; optionally open with a full-size one
  task automatic queue_random_frames(input int n_items, input bit with_max);
    stim_row_t row;
    int        sent;
    int        len;
    int        r;
    sent = 0;
    row.n_typed = 0;
    while (sent < n_items || with_max) begin
      r = $urandom_range(99);
      if (with_max) len = int'(MaxPayload);
      else if (r < 8) len = $urandom_range(255, int'(MaxPayload) + 1);
      else if (r < 18) len = 0;
      else if (r < 88) len = $urandom_range(6, 1);
      else len = $urandom_range(40, 7);
      with_max = 1'b0;
      row.item.dest_address = 8'($urandom);
      row.item.payload_len = 8'(len);
      row.item.data_byte = 8'($urandom);
      queue_item(row);
      sent++;
      for (int k = 1; k < len && len <= int'(MaxPayload); k++) begin
        row.item = 24'($urandom);  // header fields are don't-care inside a frame
        queue_item(row);
        sent++;
      end
    end
  endtask

  // Wait until every item is taken, every byte has arrived, and the pipe is empty
  task automatic drain();
    while (items_taken != items_queued) @(posedge clk);
    while (frame_bytes_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NODE_ADDRESS: cfg_shadow.node_address = val;
      REG_HEADER_START: cfg_shadow.header_start_code = val;
      REG_TEXT_START:   cfg_shadow.text_start_code = val;
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [7:0] node, input logic [7:0] soh,
                           input logic [7:0] stx);
    write_reg(REG_UNUSED, 8'($urandom));
    write_reg(REG_NODE_ADDRESS, node);
    write_reg(REG_HEADER_START, soh);
    write_reg(REG_TEXT_START, stx);
  endtask

  initial begin
    stim_row_t row;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at reset register values
    foreach (dir_item[i]) begin
      row.item = dir_item[i];
      row.n_typed = dir_typed_n[i];
      for (int k = 0; k < row.n_typed; k++) row.typed[k] = dir_typed.pop_front();
      queue_item(row);
    end
    drain();

    load_regs(8'hFF, 8'hFF, 8'hFF);
    queue_random_frames(25, 1'b0);
    drain();

    // Full-rate stretch: no gaps, no stalls
    gap_pct = 0;
    load_regs(8'h00, 8'h00, 8'h00);
    queue_random_frames(30, 1'b0);
    drain();

    gap_pct = 24;
    load_regs(8'($urandom), 8'($urandom), 8'($urandom));
    queue_random_frames(25, 1'b0);
    drain();

    load_regs(8'($urandom), 8'($urandom), 8'($urandom));
    queue_random_frames(25, 1'b0);
    drain();

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
